// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// expression never holds
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== sv/mcgp_pkg.sv =====
`default_nettype none

package mcgp_pkg;

  // grid geometry
  localparam int unsigned GRID_ROWS = 8;
  localparam int unsigned GRID_COLS = 16;
  localparam int unsigned ROW_W     = $clog2(GRID_ROWS);
  localparam int unsigned COL_W     = $clog2(GRID_COLS);

  // field widths
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned COST_W     = 12;
  localparam int unsigned PATH_ROW_W = 3;

  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [COL_W-1:0]    col_t;
  typedef logic [COST_W-1:0]   cost_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  localparam cost_t COST_MAX = {COST_W{1'b1}};

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACE_START,
    ST_TRACE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== sv/min_cost_grid_path_wrap_core.sv =====
`default_nettype none

// Minimum-cost left-to-right path through a grid with wrapping rows. Weights are taken one
// per cycle, column by column, top row first; the column costs sit in a two-bank cost
// memory (one bank per column parity) read one row ahead through a small window, and the
// chosen predecessor of every cell past the left column goes to a predecessor memory. After
// the last weight of a grid the input stalls: the traceback walks the predecessor memory one
// column per cycle, as its single read port and the dependent row address allow, and the
// path is then sent out left to right, each result read from the path buffer before it is
// offered. Every result carries the total cost; last_of_run_o marks the right column. No
// memory needs clearing after reset.
module min_cost_grid_path_wrap_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [mcgp_pkg::WEIGHT_W-1:0]       cell_weight_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [mcgp_pkg::PATH_ROW_W-1:0]          path_row_o,
  output logic [mcgp_pkg::COST_W-1:0]              path_cost_o,
  output logic                                     last_of_run_o
);

  localparam int unsigned CostAddrW = mcgp_pkg::ROW_W + 1;
  localparam int unsigned PredAddrW = mcgp_pkg::COL_W + mcgp_pkg::ROW_W;

  mcgp_pkg::state_e state_q, state_d;
  mcgp_pkg::row_t   row_q;
  mcgp_pkg::col_t   col_q;
  mcgp_pkg::col_t   idx_q, idx_d;

  // cost window and column edge registers
  mcgp_pkg::cost_t  win_a_q, win_b_q;
  mcgp_pkg::cost_t  first_cur_q, first_prev_q, last_prev_q;
  mcgp_pkg::cost_t  bestcost_q;
  mcgp_pkg::row_t   best_q;

  // memories
  mcgp_pkg::cost_t  cost_mem [2**CostAddrW];
  mcgp_pkg::cost_t  cost_rd_q;
  logic [CostAddrW-1:0] cost_waddr, cost_raddr;
  mcgp_pkg::row_t   pred_mem [2**PredAddrW];
  mcgp_pkg::row_t   pred_rd_q;
  logic             pred_re;
  logic [PredAddrW-1:0] pred_raddr;
  mcgp_pkg::row_t   pb_mem [2**mcgp_pkg::COL_W];
  mcgp_pkg::row_t   pb_rd_q;
  logic             pb_we, pb_re;
  mcgp_pkg::col_t   pb_waddr, pb_raddr;
  mcgp_pkg::row_t   pb_wdata;

  logic             acc, row_last, col_last, col_first, grid_end, out_done;
  mcgp_pkg::cost_t  up_cost, down_cost, min_cost, cost_new;
  mcgp_pkg::row_t   up_row, down_row, min_row;
  logic [mcgp_pkg::COST_W:0] sum;

  assign acc       = in_valid_i && in_ready_o;
  assign row_last  = row_q == mcgp_pkg::row_t'(mcgp_pkg::GRID_ROWS - 1);
  assign col_last  = col_q == mcgp_pkg::col_t'(mcgp_pkg::GRID_COLS - 1);
  assign col_first = col_q == '0;
  assign grid_end  = acc && row_last && col_last;

  // three predecessors, wrapping at top and bottom
  always_comb begin
    up_cost   = (row_q == '0) ? last_prev_q : win_a_q;
    up_row    = row_q - mcgp_pkg::row_t'(1);
    if (row_q == '0) begin
      up_row = mcgp_pkg::row_t'(mcgp_pkg::GRID_ROWS - 1);
    end
    down_cost = row_last ? first_prev_q : cost_rd_q;
    down_row  = row_last ? '0 : row_q + mcgp_pkg::row_t'(1);
    // ties keep the earlier choice: up, then same, then down
    min_cost  = up_cost;
    min_row   = up_row;
    if (win_b_q < min_cost) begin
      min_cost = win_b_q;
      min_row  = row_q;
    end
    if (down_cost < min_cost) begin
      min_cost = down_cost;
      min_row  = down_row;
    end
    sum = {1'b0, min_cost} + (mcgp_pkg::COST_W + 1)'(cell_weight_i);
    if (col_first) begin
      cost_new = mcgp_pkg::COST_W'(cell_weight_i);
    end else if (sum[mcgp_pkg::COST_W]) begin
      cost_new = mcgp_pkg::COST_MAX;
    end else begin
      cost_new = sum[mcgp_pkg::COST_W-1:0];
    end
  end

  // cost memory addressing: write current bank, prefetch two rows ahead in the previous
  // bank, or row one of the column just finished at its last row
  always_comb begin
    cost_waddr = {col_q[0], row_q};
    if (row_last) begin
      cost_raddr = {col_q[0], mcgp_pkg::row_t'(1)};
    end else begin
      cost_raddr = {~col_q[0], row_q + mcgp_pkg::row_t'(2)};
    end
  end

  // cost memory with write-to-read forwarding
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cost_mem[cost_waddr] <= cost_new;
      if (cost_waddr == cost_raddr) begin
        cost_rd_q <= cost_new;
      end else begin
        cost_rd_q <= cost_mem[cost_raddr];
      end
    end
  end

  // predecessor memory
  always_ff @(posedge clk_i) begin
    if (acc && !col_first) begin
      pred_mem[{col_q, row_q}] <= min_row;
    end
    if (pred_re) begin
      pred_rd_q <= pred_mem[pred_raddr];
    end
  end

  // path buffer
  always_ff @(posedge clk_i) begin
    if (pb_we) begin
      pb_mem[pb_waddr] <= pb_wdata;
    end
    if (pb_re) begin
      pb_rd_q <= pb_mem[pb_raddr];
    end
  end

  // window, column edges and running minimum
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (row_last) begin
        win_b_q      <= first_cur_q;
        first_prev_q <= first_cur_q;
        last_prev_q  <= cost_new;
      end else begin
        win_a_q <= win_b_q;
        win_b_q <= cost_rd_q;
      end
      if (row_q == '0) begin
        first_cur_q <= cost_new;
        bestcost_q  <= cost_new;
        best_q      <= '0;
      end else if (cost_new < bestcost_q) begin
        bestcost_q <= cost_new;
        best_q     <= row_q;
      end
    end
  end

  // input counters and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcgp_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (acc) begin
        if (row_last) begin
          row_q <= '0;
          col_q <= col_last ? '0 : col_q + mcgp_pkg::col_t'(1);
        end else begin
          row_q <= row_q + mcgp_pkg::row_t'(1);
        end
      end
    end
  end

  // traceback and emission sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pred_re    = 1'b0;
    pred_raddr = {idx_q, pred_rd_q};
    pb_we      = 1'b0;
    pb_waddr   = idx_q - mcgp_pkg::col_t'(1);
    pb_wdata   = pred_rd_q;
    pb_re      = 1'b0;
    pb_raddr   = idx_q;
    case (state_q)
      mcgp_pkg::ST_IDLE: begin
        if (grid_end) begin
          state_d = mcgp_pkg::ST_TRACE_START;
        end
      end
      mcgp_pkg::ST_TRACE_START: begin
        pb_we      = 1'b1;
        pb_waddr   = mcgp_pkg::col_t'(mcgp_pkg::GRID_COLS - 1);
        pb_wdata   = best_q;
        pred_re    = 1'b1;
        pred_raddr = {mcgp_pkg::col_t'(mcgp_pkg::GRID_COLS - 1), best_q};
        idx_d      = mcgp_pkg::col_t'(mcgp_pkg::GRID_COLS - 1);
        state_d    = mcgp_pkg::ST_TRACE;
      end
      mcgp_pkg::ST_TRACE: begin
        pb_we = 1'b1;
        if (idx_q == mcgp_pkg::col_t'(1)) begin
          idx_d   = '0;
          state_d = mcgp_pkg::ST_EMIT_RD;
        end else begin
          pred_re    = 1'b1;
          pred_raddr = {idx_q - mcgp_pkg::col_t'(1), pred_rd_q};
          idx_d      = idx_q - mcgp_pkg::col_t'(1);
        end
      end
      mcgp_pkg::ST_EMIT_RD: begin
        pb_re   = 1'b1;
        state_d = mcgp_pkg::ST_EMIT_OUT;
      end
      mcgp_pkg::ST_EMIT_OUT: begin
        if (out_ready_i) begin
          if (idx_q == mcgp_pkg::col_t'(mcgp_pkg::GRID_COLS - 1)) begin
            idx_d   = '0;
            state_d = mcgp_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + mcgp_pkg::col_t'(1);
            state_d = mcgp_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = mcgp_pkg::ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  // handshake and result fields
  assign in_ready_o    = state_q == mcgp_pkg::ST_IDLE;
  assign out_valid_o   = state_q == mcgp_pkg::ST_EMIT_OUT;
  assign path_row_o    = mcgp_pkg::PATH_ROW_W'(pb_rd_q);
  assign path_cost_o   = bestcost_q;
  assign last_of_run_o = idx_q == mcgp_pkg::col_t'(mcgp_pkg::GRID_COLS - 1);
  assign out_done      = out_valid_o && out_ready_i && last_of_run_o;

  // checks
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_in_out_exclusive, in_ready_o && out_valid_o, "input and output both open")
  `ASSERT_NEXT(a_grid_end_trace, grid_end, state_q == mcgp_pkg::ST_TRACE_START, "no traceback")
  `ASSERT_IMPLIES(a_counters_idle, !in_ready_o, row_q == '0 && col_q == '0, "counters not clear")
  `ASSERT_NEXT(a_run_end_idle, out_done, in_ready_o, "input not reopened after last transfer")

endmodule

`default_nettype wire

// ===== sim/min_cost_grid_path_wrap_core_tb.sv =====
`default_nettype none

module min_cost_grid_path_wrap_core_tb;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned CELLS_PER_GRID = mcgp_pkg::GRID_ROWS * mcgp_pkg::GRID_COLS;
  localparam int unsigned TAIL_CYCLES    = 3 * mcgp_pkg::GRID_COLS + 16;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned MAX_REPORTED   = 10;
  localparam int unsigned HOLD_OFF_LEN   = 400;
  localparam int unsigned SPLIT_ITEMS    = 40;
  localparam int unsigned TAIL_ITEMS     = 24;

  typedef struct packed {
    logic [mcgp_pkg::PATH_ROW_W-1:0] row;
    mcgp_pkg::cost_t                 cost;
    logic                            last;
  } path_step_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  mcgp_pkg::weight_t               cell_weight_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [mcgp_pkg::PATH_ROW_W-1:0] path_row_o;
  mcgp_pkg::cost_t                 path_cost_o;
  logic                            last_of_run_o;

  // path predictor state
  mcgp_pkg::cost_t prev_col_cost [mcgp_pkg::GRID_ROWS];
  mcgp_pkg::cost_t cur_col_cost  [mcgp_pkg::GRID_ROWS];
  mcgp_pkg::row_t  pred_row      [mcgp_pkg::GRID_COLS][mcgp_pkg::GRID_ROWS];
  int unsigned     fill_row;
  int unsigned     fill_col;
  path_step_t      expected_path_q [$];

  int unsigned fail_count;
  bit          idling_on;
  int unsigned hold_off_cycles;

  min_cost_grid_path_wrap_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_weight_i (cell_weight_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .path_row_o    (path_row_o),
    .path_cost_o   (path_cost_o),
    .last_of_run_o (last_of_run_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // cost update for one accepted weight; traceback once the grid is full
  function automatic void predict_cell(mcgp_pkg::weight_t w);
    int unsigned               r;
    int unsigned               ru;
    int unsigned               rd;
    int unsigned               best;
    int unsigned               k;
    mcgp_pkg::cost_t           m;
    mcgp_pkg::cost_t           best_cost;
    mcgp_pkg::row_t            pr;
    logic [mcgp_pkg::COST_W:0] sum;
    mcgp_pkg::row_t            trace [mcgp_pkg::GRID_COLS];
    path_step_t                step;

    r = fill_row;
    if (fill_col == 0) begin
      cur_col_cost[r] = mcgp_pkg::cost_t'(w);
    end else begin
      ru = (r + mcgp_pkg::GRID_ROWS - 1) % mcgp_pkg::GRID_ROWS;
      rd = (r + 1) % mcgp_pkg::GRID_ROWS;
      // up wins ties, then same row, then down
      m  = prev_col_cost[ru];
      pr = mcgp_pkg::row_t'(ru);
      if (prev_col_cost[r] < m) begin
        m  = prev_col_cost[r];
        pr = mcgp_pkg::row_t'(r);
      end
      if (prev_col_cost[rd] < m) begin
        m  = prev_col_cost[rd];
        pr = mcgp_pkg::row_t'(rd);
      end
      pred_row[fill_col][r] = pr;
      sum = {1'b0, m} + (mcgp_pkg::COST_W + 1)'(w);
      cur_col_cost[r] = (sum > mcgp_pkg::COST_MAX) ? mcgp_pkg::COST_MAX
                                                   : sum[mcgp_pkg::COST_W-1:0];
    end

    fill_row++;
    if (fill_row < mcgp_pkg::GRID_ROWS) return;
    fill_row = 0;
    prev_col_cost = cur_col_cost;
    fill_col++;
    if (fill_col < mcgp_pkg::GRID_COLS) return;
    fill_col = 0;

    // lowest row wins ties in the right column
    best      = 0;
    best_cost = prev_col_cost[0];
    for (k = 1; k < mcgp_pkg::GRID_ROWS; k++) begin
      if (prev_col_cost[k] < best_cost) begin
        best_cost = prev_col_cost[k];
        best      = k;
      end
    end

    trace[mcgp_pkg::GRID_COLS-1] = mcgp_pkg::row_t'(best);
    for (k = mcgp_pkg::GRID_COLS - 1; k > 0; k--) begin
      trace[k-1] = pred_row[k][trace[k]];
    end

    for (k = 0; k < mcgp_pkg::GRID_COLS; k++) begin
      step.row  = mcgp_pkg::PATH_ROW_W'(trace[k]);
      step.cost = best_cost;
      step.last = (k == mcgp_pkg::GRID_COLS - 1);
      expected_path_q.push_back(step);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    path_step_t exp_step;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_path_q.size() == 0) begin
        if (fail_count < MAX_REPORTED) begin
          $display("unexpected result: row %0d cost %0d last %0b",
                   path_row_o, path_cost_o, last_of_run_o);
        end
        fail_count++;
      end else begin
        exp_step = expected_path_q.pop_front();
        if (path_row_o !== exp_step.row || path_cost_o !== exp_step.cost ||
            last_of_run_o !== exp_step.last) begin
          if (fail_count < MAX_REPORTED) begin
            $display("mismatch: row exp %0d act %0d, cost exp %0d act %0d, last exp %0b act %0b",
                     exp_step.row, path_row_o, exp_step.cost, path_cost_o,
                     exp_step.last, last_of_run_o);
          end
          fail_count++;
        end
      end
    end
  end

  // receiver: random gap per transfer, plus a long hold-off on request
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = idling_on ? $urandom_range(0, 12) : 0;
      gap += hold_off_cycles;
      hold_off_cycles = 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_off_cycles == 0);
    end
  end

  // one weight transfer, with a random gap ahead of it
  task automatic send_weight(input mcgp_pkg::weight_t w);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cell_weight_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cell(w);
    @(negedge clk_i);
  endtask

  // wait for every pending result, bounded
  task automatic wait_results_drained();
    int unsigned n;
    n = 0;
    while (expected_path_q.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    @(negedge clk_i);
  endtask

  // all cells at maximum weight: ties everywhere, largest total cost
  task automatic test_flat_max_grid();
    idling_on = 1'b0;
    repeat (CELLS_PER_GRID) send_weight(mcgp_pkg::weight_t'(8'hFF));
  endtask

  // receiver holds off after a grid; the sender, going on into the next grid, waits until the results are out
  task automatic test_output_backpressure();
    idling_on       = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (SPLIT_ITEMS) send_weight(mcgp_pkg::weight_t'($urandom_range(0, 255)));
  endtask

  // narrow weights so that predecessor and right-column ties are frequent
  task automatic test_tie_heavy_grid();
    idling_on = 1'b1;
    repeat (CELLS_PER_GRID - SPLIT_ITEMS) send_weight(mcgp_pkg::weight_t'($urandom_range(0, 2)));
  endtask

  // sender pauses until all results are out, then starts a further grid
  task automatic test_pause_until_drained();
    in_valid_i <= 1'b0;
    wait_results_drained();
    idling_on = 1'b1;
    repeat (TAIL_ITEMS) send_weight(mcgp_pkg::weight_t'($urandom_range(0, 255)));
  endtask

  // main sequence
  initial begin
    fail_count      = 0;
    idling_on       = 1'b0;
    hold_off_cycles = 0;
    fill_row        = 0;
    fill_col        = 0;
    for (int i = 0; i < mcgp_pkg::GRID_ROWS; i++) begin
      prev_col_cost[i] = '0;
      cur_col_cost[i]  = '0;
    end
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cell_weight_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_flat_max_grid();
    test_output_backpressure();
    test_tie_heavy_grid();
    test_pause_until_drained();

    in_valid_i <= 1'b0;
    wait_results_drained();
    if (expected_path_q.size() > 0) begin
      if (fail_count < MAX_REPORTED) begin
        $display("%0d expected results never arrived", expected_path_q.size());
      end
      fail_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
